// ----- sv/sfd_pkg.sv -----
// Package for the stereo feedback delay: register codes, gain format and the
// configuration struct passed from the register block to the datapath.
// No dependencies.
package sfd_pkg;

    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 15;
    localparam int DELAY_BITS    = 15;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_DELAY    = 2'd1,
        REG_MIX      = 2'd2,
        REG_FEEDBACK = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                  enable;
        logic [DELAY_BITS-1:0] delay_pairs;
        logic [GAIN_BITS-1:0]  mix_gain;
        logic [GAIN_BITS-1:0]  feedback_gain;
    } cfg_t;

endpackage

// ----- sv/sfd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sfd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sfd_cfg.sv -----
// APB register block of the stereo feedback delay.
// Depends on sfd_pkg.
module sfd_cfg import sfd_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t reg_sel;
    logic     wr_en;

    assign reg_sel = cfg_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENABLE:   cfg_next.enable        = pwdata[0];
                REG_DELAY:    cfg_next.delay_pairs   = pwdata[DELAY_BITS-1:0];
                REG_MIX:      cfg_next.mix_gain      = pwdata[GAIN_BITS-1:0];
                REG_FEEDBACK: cfg_next.feedback_gain = pwdata[GAIN_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ENABLE:
                prdata = {{(CFG_DATA_BITS-1){1'b0}}, cfg_reg.enable};
            REG_DELAY:
                prdata = {{(CFG_DATA_BITS-DELAY_BITS){1'b0}}, cfg_reg.delay_pairs};
            REG_MIX:
                prdata = {{(CFG_DATA_BITS-GAIN_BITS){1'b0}}, cfg_reg.mix_gain};
            REG_FEEDBACK:
                prdata = {{(CFG_DATA_BITS-GAIN_BITS){1'b0}}, cfg_reg.feedback_gain};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/sfd_pipe.sv -----
// Echo datapath: write pointer, two copies of the pair store (tap and oldest),
// forwarding of in-flight writes, gain multipliers and the output register.
// Depends on sfd_pkg and sfd_ram.
module sfd_pipe import sfd_pkg::*; #(
    parameter int STORE_FRAMES = 16384,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] proc_left,
    input  logic signed [SAMPLE_BITS-1:0] proc_right,
    input  logic signed [SAMPLE_BITS-1:0] dry_left,
    input  logic signed [SAMPLE_BITS-1:0] dry_right,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right
);

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = $clog2(STORE_FRAMES);
    localparam int PW     = AW + 1;
    localparam int DLW    = (PW > DELAY_BITS) ? PW : DELAY_BITS;
    localparam int PRODW  = SB + GAIN_BITS + 1;
    localparam int QW     = PRODW - GAIN_FRAC;
    localparam int SUMW   = QW + 1;
    localparam int PAIR_W = 2 * SB;

    localparam logic [AW-1:0]  LAST_IDX = AW'(STORE_FRAMES - 1);
    localparam logic [PW-1:0]  DEPTH_P  = PW'(STORE_FRAMES);
    localparam logic [DLW-1:0] DEPTH_D  = DLW'(STORE_FRAMES);

    function automatic logic signed [PRODW-1:0] gmul(
        input logic signed [SB-1:0]  x,
        input logic [GAIN_BITS-1:0]  g
    );
        logic signed [PRODW-1:0] xe;
        logic signed [PRODW-1:0] ge;
        begin
            xe = {{(PRODW-SB){x[SB-1]}}, x};
            ge = $signed({{(PRODW-GAIN_BITS){1'b0}}, g});
            return xe * ge;
        end
    endfunction

    function automatic logic signed [QW-1:0] scale(input logic signed [PRODW-1:0] p);
        logic [QW-1:0] q;
        begin
            q = p[PRODW-1:GAIN_FRAC];
            if (p[PRODW-1] && (|p[GAIN_FRAC-1:0]))
            begin
                q = q + QW'(1);
            end
            return $signed(q);
        end
    endfunction

    function automatic logic signed [SB-1:0] sat_add(
        input logic signed [SB-1:0] d,
        input logic signed [QW-1:0] q
    );
        logic signed [SUMW-1:0] s;
        begin
            s = $signed({{(SUMW-SB){d[SB-1]}}, d}) + $signed({q[QW-1], q});
            if ((&s[SUMW-1:SB-1]) || !(|s[SUMW-1:SB-1]))
            begin
                return s[SB-1:0];
            end
            else if (s[SUMW-1])
            begin
                return {1'b1, {(SB-1){1'b0}}};
            end
            else
            begin
                return {1'b0, {(SB-1){1'b1}}};
            end
        end
    endfunction

    logic advance;
    logic accept;

    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] wptr_next;
    logic          wrapped_reg;
    logic          wrapped_next;

    logic [DLW-1:0] d_ext;
    logic [DLW-1:0] d_clamp_wide;
    logic [PW-1:0]  d_clamp;
    logic [PW:0]    tap_sum;
    logic [PW:0]    tap_fix;
    logic [AW-1:0]  tap_addr;
    logic           tap_known;
    logic           tap_on;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_write_reg;
    logic                 s1_tap_reg;
    logic                 s1_tap_known_reg;
    logic                 s1_old_known_reg;
    logic [AW-1:0]        s1_waddr_reg;
    logic [AW-1:0]        s1_taddr_reg;
    logic signed [SB-1:0] s1_dry_l_reg;
    logic signed [SB-1:0] s1_dry_r_reg;
    logic signed [SB-1:0] s1_proc_l_reg;
    logic signed [SB-1:0] s1_proc_r_reg;

    logic [PAIR_W-1:0]       ram_tap_data;
    logic [PAIR_W-1:0]       ram_old_data;
    logic [PAIR_W-1:0]       old_pair;
    logic [PAIR_W-1:0]       tap_pair;
    logic signed [PRODW-1:0] fb_prod_l;
    logic signed [PRODW-1:0] fb_prod_r;

    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    logic                    s2_write_reg;
    logic                    s2_tap_reg;
    logic [AW-1:0]           s2_waddr_reg;
    logic signed [SB-1:0]    s2_dry_l_reg;
    logic signed [SB-1:0]    s2_dry_r_reg;
    logic signed [SB-1:0]    s2_proc_l_reg;
    logic signed [SB-1:0]    s2_proc_r_reg;
    logic signed [PRODW-1:0] s2_fb_l_reg;
    logic signed [PRODW-1:0] s2_fb_r_reg;
    logic signed [SB-1:0]    s2_tap_l_reg;
    logic signed [SB-1:0]    s2_tap_r_reg;
    logic signed [SB-1:0]    new_l;
    logic signed [SB-1:0]    new_r;
    logic [PAIR_W-1:0]       new_pair;
    logic                    ram_we;
    logic signed [PRODW-1:0] mix_prod_l;
    logic signed [PRODW-1:0] mix_prod_r;

    logic                    lw_valid_reg;
    logic                    lw_valid_next;
    logic [AW-1:0]           lw_addr_reg;
    logic [PAIR_W-1:0]       lw_data_reg;

    logic                    s3_valid_reg;
    logic                    s3_valid_next;
    logic                    s3_tap_reg;
    logic signed [SB-1:0]    s3_dry_l_reg;
    logic signed [SB-1:0]    s3_dry_r_reg;
    logic signed [SB-1:0]    s3_proc_l_reg;
    logic signed [SB-1:0]    s3_proc_r_reg;
    logic signed [PRODW-1:0] s3_mix_l_reg;
    logic signed [PRODW-1:0] s3_mix_r_reg;
    logic signed [SB-1:0]    res_l;
    logic signed [SB-1:0]    res_r;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [SB-1:0] out_left_reg;
    logic signed [SB-1:0] out_right_reg;

    assign advance  = !s3_valid_reg || !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    // Read address of the delay tap, clamped delay and fill tracking.
    assign d_ext        = DLW'(cfg.delay_pairs);
    assign d_clamp_wide = (d_ext > DEPTH_D) ? DEPTH_D : d_ext;
    assign d_clamp      = d_clamp_wide[PW-1:0];
    assign tap_sum      = {2'b00, wptr_reg} + {1'b0, DEPTH_P} - {1'b0, d_clamp};
    assign tap_fix      = (tap_sum >= {1'b0, DEPTH_P}) ? (tap_sum - {1'b0, DEPTH_P}) : tap_sum;
    assign tap_addr     = tap_fix[AW-1:0];
    assign tap_known    = wrapped_reg || (tap_addr < wptr_reg);
    assign tap_on       = cfg.enable && (d_clamp != '0);

    always_comb
    begin
        wptr_next    = wptr_reg;
        wrapped_next = wrapped_reg;
        if (accept && cfg.enable)
        begin
            if (wptr_reg == LAST_IDX)
            begin
                wptr_next    = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wptr_next = wptr_reg + AW'(1);
            end
        end
    end

    sfd_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (STORE_FRAMES)
    ) u_tap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_waddr_reg),
        .wdata (new_pair),
        .re    (advance),
        .raddr (tap_addr),
        .rdata (ram_tap_data)
    );

    sfd_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (STORE_FRAMES)
    ) u_old_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_waddr_reg),
        .wdata (new_pair),
        .re    (advance),
        .raddr (wptr_reg),
        .rdata (ram_old_data)
    );

    // The oldest entry can only collide with the write two frames back.
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == s1_waddr_reg))
        begin
            old_pair = lw_data_reg;
        end
        else if (s1_old_known_reg)
        begin
            old_pair = ram_old_data;
        end
        else
        begin
            old_pair = '0;
        end
    end

    always_comb
    begin
        if (s2_valid_reg && s2_write_reg && (s2_waddr_reg == s1_taddr_reg))
        begin
            tap_pair = new_pair;
        end
        else if (lw_valid_reg && (lw_addr_reg == s1_taddr_reg))
        begin
            tap_pair = lw_data_reg;
        end
        else if (s1_tap_known_reg)
        begin
            tap_pair = ram_tap_data;
        end
        else
        begin
            tap_pair = '0;
        end
    end

    assign fb_prod_l = gmul($signed(old_pair[SB-1:0]), cfg.feedback_gain);
    assign fb_prod_r = gmul($signed(old_pair[PAIR_W-1:SB]), cfg.feedback_gain);

    assign new_l    = sat_add(s2_dry_l_reg, scale(s2_fb_l_reg));
    assign new_r    = sat_add(s2_dry_r_reg, scale(s2_fb_r_reg));
    assign new_pair = {new_r, new_l};
    assign ram_we   = advance && s2_valid_reg && s2_write_reg;

    assign mix_prod_l = gmul(s2_tap_l_reg, cfg.mix_gain);
    assign mix_prod_r = gmul(s2_tap_r_reg, cfg.mix_gain);

    assign res_l = s3_tap_reg ? sat_add(s3_dry_l_reg, scale(s3_mix_l_reg)) : s3_proc_l_reg;
    assign res_r = s3_tap_reg ? sat_add(s3_dry_r_reg, scale(s3_mix_r_reg)) : s3_proc_r_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        lw_valid_next = lw_valid_reg;
        if (advance)
        begin
            s1_valid_next = accept;
            s2_valid_next = s1_valid_reg;
            s3_valid_next = s2_valid_reg;
            lw_valid_next = s2_valid_reg && s2_write_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && s3_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            wrapped_reg   <= wrapped_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            lw_valid_reg  <= lw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_write_reg     <= cfg.enable;
            s1_tap_reg       <= tap_on;
            s1_tap_known_reg <= tap_known;
            s1_old_known_reg <= wrapped_reg;
            s1_waddr_reg     <= wptr_reg;
            s1_taddr_reg     <= tap_addr;
            s1_dry_l_reg     <= dry_left;
            s1_dry_r_reg     <= dry_right;
            s1_proc_l_reg    <= proc_left;
            s1_proc_r_reg    <= proc_right;

            s2_write_reg  <= s1_write_reg;
            s2_tap_reg    <= s1_tap_reg;
            s2_waddr_reg  <= s1_waddr_reg;
            s2_dry_l_reg  <= s1_dry_l_reg;
            s2_dry_r_reg  <= s1_dry_r_reg;
            s2_proc_l_reg <= s1_proc_l_reg;
            s2_proc_r_reg <= s1_proc_r_reg;
            s2_fb_l_reg   <= fb_prod_l;
            s2_fb_r_reg   <= fb_prod_r;
            s2_tap_l_reg  <= $signed(tap_pair[SB-1:0]);
            s2_tap_r_reg  <= $signed(tap_pair[PAIR_W-1:SB]);

            lw_addr_reg <= s2_waddr_reg;
            lw_data_reg <= new_pair;

            s3_tap_reg    <= s2_tap_reg;
            s3_dry_l_reg  <= s2_dry_l_reg;
            s3_dry_r_reg  <= s2_dry_r_reg;
            s3_proc_l_reg <= s2_proc_l_reg;
            s3_proc_r_reg <= s2_proc_r_reg;
            s3_mix_l_reg  <= mix_prod_l;
            s3_mix_r_reg  <= mix_prod_r;
        end
        if (advance && s3_valid_reg)
        begin
            out_left_reg  <= res_l;
            out_right_reg <= res_r;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule

// ----- sv/stereo_feedback_delay_top.sv -----
// Top level of the stereo feedback delay: stream ports, APB register block
// and the echo datapath. Depends on sfd_pkg, sfd_cfg and sfd_pipe.
//
//   Channel   Direction   Handshake          Payload
//   s_*       in          tvalid / tready    proc_left, proc_right, dry_left, dry_right
//   m_*       out         tvalid / tready    out_left, out_right
//   APB       in          psel / penable     enable, delay_pairs, mix_gain, feedback_gain
//
// One frame is accepted per cycle while s_tready is high; a result passes the s1,
// s2 and s3 registers and the output register. The rate is set by one read of the
// tap copy, one read of the oldest-entry copy and one write of both store copies
// per frame. Reset clears the pointer, a wrap flag and the pipeline; the store has
// no clearing pass, since entries not yet written read as zero by the wrap flag.
// s_tready drops only while s3 and the output register are full and m_tready is low.
module stereo_feedback_delay_top import sfd_pkg::*; #(
    parameter int STORE_FRAMES = 16384,
    parameter int SAMPLE_BITS  = 24,
    localparam int IN_W  = ((4 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_W-1:0]          s_tdata,  // proc_left, proc_right, dry_left, dry_right
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata,  // out_left, out_right
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int SB = SAMPLE_BITS;

    cfg_t                 cfg;
    logic signed [SB-1:0] proc_left;
    logic signed [SB-1:0] proc_right;
    logic signed [SB-1:0] dry_left;
    logic signed [SB-1:0] dry_right;
    logic signed [SB-1:0] out_left;
    logic signed [SB-1:0] out_right;

    assign proc_left  = $signed(s_tdata[SB-1:0]);
    assign proc_right = $signed(s_tdata[2*SB-1:SB]);
    assign dry_left   = $signed(s_tdata[3*SB-1:2*SB]);
    assign dry_right  = $signed(s_tdata[4*SB-1:3*SB]);

    sfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfd_pipe #(
        .STORE_FRAMES (STORE_FRAMES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .proc_left  (proc_left),
        .proc_right (proc_right),
        .dry_left   (dry_left),
        .dry_right  (dry_right),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_left   (out_left),
        .out_right  (out_right)
    );

    assign m_tdata = OUT_W'({out_right, out_left});

endmodule

// ----- bench/stereo_feedback_delay_top_tb.sv -----
// Self-checking testbench for stereo_feedback_delay_top: it drives stereo frames over the
// stream ports, programs the APB registers between phases and scores every output frame.
// Depends on sfd_pkg and the RTL of the block.
`timescale 1ns / 100ps

module stereo_feedback_delay_top_tb;
    import sfd_pkg::*;

    localparam int STORE_FRAMES = 16384;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [23:0] dry_right;
        logic signed [23:0] dry_left;
        logic signed [23:0] proc_right;
        logic signed [23:0] proc_left;
    } frame_t;

    typedef struct packed {
        logic signed [23:0] out_right;
        logic signed [23:0] out_left;
    } echo_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [95:0]              s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [47:0]              m_tdata;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    frame_t    pending_frames[$];
    echo_out_t expected_out[$];
    int        mismatch_count = 0;

    logic               cfg_enable = 1'b0;
    logic [14:0]        cfg_delay = '0;
    logic [15:0]        cfg_mix = '0;
    logic [15:0]        cfg_feedback = '0;
    logic signed [23:0] echo_left [STORE_FRAMES];
    logic signed [23:0] echo_right [STORE_FRAMES];
    logic [13:0]        echo_wr_ptr = '0;

    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;
    int stall_mode = 0;

    stereo_feedback_delay_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string field, int exp_val, int act_val);
        mismatch_count++;
        $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
    endtask

    function automatic logic signed [23:0] scaled_sum(logic signed [23:0] dry,
                                                      logic signed [23:0] x,
                                                      logic [15:0] gain);
        longint total;
        total = longint'(dry) + (longint'(x) * longint'(gain)) / 32768;
        if (total > longint'(SAMPLE_MAX))
            total = longint'(SAMPLE_MAX);
        else if (total < longint'(SAMPLE_MIN))
            total = longint'(SAMPLE_MIN);
        return 24'(total);
    endfunction

    function automatic void predict_echo(frame_t f);
        echo_out_t   r;
        int unsigned d;
        logic [13:0] tap;
        r.out_left  = f.proc_left;
        r.out_right = f.proc_right;
        if (cfg_enable)
        begin
            d = (cfg_delay > STORE_FRAMES) ? STORE_FRAMES : cfg_delay;
            tap = echo_wr_ptr - 14'(d);
            if (d != 0)
            begin
                r.out_left  = scaled_sum(f.dry_left, echo_left[tap], cfg_mix);
                r.out_right = scaled_sum(f.dry_right, echo_right[tap], cfg_mix);
            end
            echo_left[echo_wr_ptr]  = scaled_sum(f.dry_left, echo_left[echo_wr_ptr], cfg_feedback);
            echo_right[echo_wr_ptr] = scaled_sum(f.dry_right, echo_right[echo_wr_ptr],
                                                 cfg_feedback);
            echo_wr_ptr = echo_wr_ptr + 14'd1;
        end
        expected_out.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_echo(pending_frames.pop_front());
            if (s_tvalid && !s_tready)
            begin
                // Hold the current transaction until it is taken.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_frames.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_frames[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        echo_out_t act;
        echo_out_t exp_r;
        logic      ready_next;
        cycle_count++;
        if (cycle_count % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        unique case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 3) != 0);
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = cycle_count[0];
        endcase
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                act = m_tdata;
                if (expected_out.size() == 0)
                begin
                    mismatch_count++;
                    $error("output transaction arrived with nothing expected");
                end
                else
                begin
                    exp_r = expected_out.pop_front();
                    if (act.out_left !== exp_r.out_left)
                        report_mismatch("out_left", int'(exp_r.out_left), int'(act.out_left));
                    if (act.out_right !== exp_r.out_right)
                        report_mismatch("out_right", int'(exp_r.out_right), int'(act.out_right));
                end
            end
            m_tready <= ready_next;
        end
    end

    task automatic write_register(cfg_reg_t idx, logic [31:0] value);
        logic [31:0] kept;
        unique case (idx)
            REG_ENABLE:
            begin
                cfg_enable = value[0];
                kept = 32'(value[0]);
            end
            REG_DELAY:
            begin
                cfg_delay = value[14:0];
                kept = 32'(value[14:0]);
            end
            REG_MIX:
            begin
                cfg_mix = value[15:0];
                kept = 32'(value[15:0]);
            end
            REG_FEEDBACK:
            begin
                cfg_feedback = value[15:0];
                kept = 32'(value[15:0]);
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== kept)
            report_mismatch(idx.name(), int'(kept), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_frame(logic signed [23:0] pl, logic signed [23:0] pr,
                               logic signed [23:0] dl, logic signed [23:0] dr);
        frame_t f;
        f.proc_left  = pl;
        f.proc_right = pr;
        f.dry_left   = dl;
        f.dry_right  = dr;
        pending_frames.push_back(f);
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || expected_out.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [23:0] pick_sample();
        unique case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return ($urandom_range(0, 1) != 0) ? 24'sd0 : -24'sd1;
            3: return 24'sd100 - 24'($urandom_range(0, 200));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_delay();
        unique case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'd16384;
            4: return $urandom_range(16385, 32767);
            5: return $urandom_range(1, 16384);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        unique case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd32768;
            2: return 32'd65535;
            3: return 32'($urandom_range(0, 65535));
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    task automatic random_phase(int count, bit upper_junk);
        logic [31:0] junk;
        junk = upper_junk ? $urandom : 32'd0;
        write_register(REG_ENABLE, ($urandom_range(0, 5) != 0) | (junk & 32'hFFFF_FFFE));
        write_register(REG_DELAY, pick_delay() | (junk & 32'hFFFF_8000));
        write_register(REG_MIX, pick_gain() | (junk & 32'hFFFF_0000));
        write_register(REG_FEEDBACK, pick_gain() | (junk & 32'hFFFF_0000));
        repeat (count)
            queue_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < STORE_FRAMES; i++)
        begin
            echo_left[i]  = '0;
            echo_right[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: the effect is off and frames pass straight through.
        queue_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX, 24'sd5, -24'sd5);
        queue_frame(24'sd0, -24'sd1, SAMPLE_MAX, SAMPLE_MAX);
        wait_drained();

        // Unity gains with a one-frame delay drive both saturation limits.
        write_register(REG_ENABLE, 32'd1);
        write_register(REG_DELAY, 32'd1);
        write_register(REG_MIX, 32'd32768);
        write_register(REG_FEEDBACK, 32'd32768);
        queue_frame(24'sd1, 24'sd2, SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(24'sd3, 24'sd4, SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(24'sd5, 24'sd6, SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(24'sd7, 24'sd8, SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(24'sd9, 24'sd10, -24'sd1, 24'sd1);
        queue_frame(24'sd11, 24'sd12, 24'sd0, 24'sd0);
        wait_drained();

        // Zero delay passes the processed samples but still writes the store.
        write_register(REG_DELAY, 32'd0);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX, 24'sd1000, -24'sd1000);
        queue_frame(-24'sd77, 24'sd77, SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(24'sd0, 24'sd0, -24'sd3, 24'sd3);
        wait_drained();

        // A delay past the store depth is clamped; gains above unity are used as given.
        write_register(REG_DELAY, 32'd32767);
        write_register(REG_MIX, 32'd65535);
        write_register(REG_FEEDBACK, 32'd65535);
        queue_frame(24'sd1, 24'sd1, SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(24'sd2, 24'sd2, -24'sd12345, 24'sd12345);
        queue_frame(24'sd3, 24'sd3, 24'sd1, -24'sd1);
        wait_drained();

        write_register(REG_DELAY, 32'd16384);
        write_register(REG_MIX, 32'd0);
        write_register(REG_FEEDBACK, 32'd0);
        queue_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(24'sd4, 24'sd4, 24'sd99, 24'sd99);
        wait_drained();

        // Disabling freezes the store and the pointer.
        write_register(REG_ENABLE, 32'd0);
        queue_frame(-24'sd2, 24'sd2, SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(SAMPLE_MIN, SAMPLE_MIN, 24'sd0, 24'sd0);
        wait_drained();

        repeat (7)
            random_phase(200, $urandom_range(0, 1));

        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
